// ===== rtl/swer_pkg.sv =====
// swer_pkg: types and fixed constants of the sliding window event rate counter
// no dependencies
package swer_pkg;

  localparam int NOW_W    = 32;
  localparam int ADD_W    = 16;
  localparam int CFG_W    = 7;
  localparam int BUCKET_W = 24;
  localparam int TOTAL_W  = 30;

  localparam logic [CFG_W-1:0]    CFG_RESET  = 7'd60;
  localparam logic [BUCKET_W-1:0] BUCKET_MAX = 24'hFF_FFFF;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 30'h3FFF_FFFF;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_ADD
  } state_t;

endpackage

// ===== rtl/swer_ram.sv =====
// swer_ram: generic single write port, single read port ram with registered read
// no dependencies
module swer_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sliding_window_event_rate.sv =====
// sliding_window_event_rate: event count over the last window_seconds seconds
// an item that does not advance time reads its bucket, then adds to it in the add step; when
//   time advances, a walk first clears k = min(seconds advanced, window) buckets off the total
// a new item is accepted only once the last one has left the add step, which waits while a result is not taken
// reset and every window write start a clearing pass over the whole bucket ram, during
//   which no item is accepted; depends on swer_pkg, swer_ram
module sliding_window_event_rate #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swer_pkg::CFG_W-1:0]      cfg_window_seconds,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [swer_pkg::NOW_W-1:0]      in_now_seconds,
  input  logic [swer_pkg::ADD_W-1:0]      in_add_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [swer_pkg::TOTAL_W-1:0]    out_window_total
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);

  swer_pkg::state_t state_r, state_nxt;

  logic [swer_pkg::CFG_W-1:0]    window_r, window_nxt;
  logic [swer_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [swer_pkg::NOW_W-1:0]    last_r, last_nxt;
  logic [AW-1:0]                 slot_r, slot_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [WW-1:0]                 rem_r, rem_nxt;
  logic [swer_pkg::ADD_W-1:0]    add_r, add_nxt;
  logic                          from_mem_r, from_mem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [swer_pkg::TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                          wr_en, rd_en;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [swer_pkg::BUCKET_W-1:0] wr_data, rd_data;

  logic [WW-1:0]                 w_eff;
  logic [AW-1:0]                 slot_cur, slot_wrap;
  logic [WW-1:0]                 slot_inc;
  logic [swer_pkg::NOW_W-1:0]    delta;
  logic [WW-1:0]                 k_steps;
  logic [swer_pkg::BUCKET_W-1:0] bucket, room_b;
  logic [swer_pkg::TOTAL_W-1:0]  room_t, add_b, add_cut;
  logic                          out_free;

  swer_ram #(
    .WIDTH (swer_pkg::BUCKET_W),
    .DEPTH (MAX_WINDOW)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (window_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_r);
    end
  end

  assign slot_cur  = (WW'(slot_r) >= w_eff) ? '0 : slot_r;
  assign slot_inc  = WW'(slot_r) + WW'(1);
  assign slot_wrap = (slot_inc >= w_eff) ? '0 : AW'(slot_inc);
  assign delta     = in_now_seconds - last_r;
  assign k_steps   = (in_now_seconds <= last_r) ? '0 :
                     (delta < 32'(w_eff)) ? WW'(delta) : w_eff;

  // saturating add into the current bucket and the total
  assign bucket  = from_mem_r ? rd_data : '0;
  assign room_b  = swer_pkg::BUCKET_MAX - bucket;
  assign room_t  = swer_pkg::TOTAL_MAX - total_r;
  assign add_b   = (swer_pkg::TOTAL_W'(add_r) > swer_pkg::TOTAL_W'(room_b)) ?
                   swer_pkg::TOTAL_W'(room_b) : swer_pkg::TOTAL_W'(add_r);
  assign add_cut = (add_b > room_t) ? room_t : add_b;

  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = (state_r == swer_pkg::ST_IDLE) || (state_r == swer_pkg::ST_CLEAR);
  assign in_ready  = (state_r == swer_pkg::ST_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;
  assign out_window_total = out_total_r;

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    clr_nxt       = clr_r;
    rem_nxt       = rem_r;
    add_nxt       = add_r;
    from_mem_nxt  = from_mem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_total_nxt = out_total_r;
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;

    unique case (state_r)
      swer_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_WINDOW - 1)) begin
          state_nxt = swer_pkg::ST_IDLE;
        end
      end
      swer_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          add_nxt  = in_add_count;
          slot_nxt = slot_cur;
          rem_nxt  = k_steps;
          if (in_now_seconds > last_r) begin
            last_nxt = in_now_seconds;
          end
          if (k_steps == '0) begin
            rd_en        = 1'b1;
            rd_addr      = slot_cur;
            from_mem_nxt = 1'b1;
            state_nxt    = swer_pkg::ST_ADD;
          end else begin
            from_mem_nxt = 1'b0;
            state_nxt    = swer_pkg::ST_WALK;
          end
        end
      end
      swer_pkg::ST_WALK: begin
        // retire the bucket read last cycle, then step into the next one
        if (from_mem_r) begin
          total_nxt = total_r - swer_pkg::TOTAL_W'(rd_data);
          wr_en     = 1'b1;
          wr_addr   = slot_r;
        end
        if (rem_r != '0) begin
          rd_en        = 1'b1;
          rd_addr      = slot_wrap;
          slot_nxt     = slot_wrap;
          rem_nxt      = rem_r - WW'(1);
          from_mem_nxt = 1'b1;
        end else begin
          from_mem_nxt = 1'b0;
          state_nxt    = swer_pkg::ST_ADD;
        end
      end
      swer_pkg::ST_ADD: begin
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = slot_r;
          wr_data       = bucket + swer_pkg::BUCKET_W'(add_cut);
          total_nxt     = total_r + add_cut;
          out_total_nxt = total_r + add_cut;
          out_valid_nxt = 1'b1;
          state_nxt     = swer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swer_pkg::ST_CLEAR;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      window_nxt = cfg_window_seconds;
      total_nxt  = '0;
      slot_nxt   = '0;
      clr_nxt    = '0;
      state_nxt  = swer_pkg::ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swer_pkg::ST_CLEAR;
      window_r    <= swer_pkg::CFG_RESET;
      total_r     <= '0;
      last_r      <= '0;
      slot_r      <= '0;
      clr_r       <= '0;
      rem_r       <= '0;
      from_mem_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      total_r     <= total_nxt;
      last_r      <= last_nxt;
      slot_r      <= slot_nxt;
      clr_r       <= clr_nxt;
      rem_r       <= rem_nxt;
      from_mem_r  <= from_mem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_r       <= add_nxt;
    out_total_r <= out_total_nxt;
  end

  // walk never reads the bucket it is clearing
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("bucket read and write collide");

  // a result only comes out of the add step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == swer_pkg::ST_ADD))
    else $error("result raised outside add step");

  // the ring position stays inside the active window once items flow
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swer_pkg::ST_WALK || state_r == swer_pkg::ST_ADD) |->
      (WW'(slot_r) < w_eff))
    else $error("slot outside window");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for sliding_window_event_rate, with random pacing on both channels
// keeps its own copy of the bucket ring to predict every window total
// depends on swer_pkg and the sliding_window_event_rate rtl
module testbench;

  localparam int WINDOW_SLOTS = 64;

  typedef struct packed {
    logic [swer_pkg::NOW_W-1:0] now;
    logic [swer_pkg::ADD_W-1:0] add;
  } stamp_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [swer_pkg::CFG_W-1:0] cfg_window_seconds = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [swer_pkg::NOW_W-1:0] in_now_seconds = '0;
  logic [swer_pkg::ADD_W-1:0] in_add_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [swer_pkg::TOTAL_W-1:0] out_window_total;

  stamp_t arrivals[$];
  logic [swer_pkg::TOTAL_W-1:0] totals_due[$];
  stamp_t next_item;
  logic [swer_pkg::TOTAL_W-1:0] want_total;
  logic [swer_pkg::NOW_W-1:0] gen_now = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;

  logic [swer_pkg::BUCKET_W-1:0] bucket_q [WINDOW_SLOTS];
  logic [swer_pkg::TOTAL_W-1:0] total_q;
  logic [swer_pkg::NOW_W-1:0] last_q = '0;
  int unsigned slot_q;
  logic [swer_pkg::CFG_W-1:0] window_q;

  sliding_window_event_rate #(
    .MAX_WINDOW(WINDOW_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_window_seconds(cfg_window_seconds),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_now_seconds(in_now_seconds),
    .in_add_count(in_add_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_window_total(out_window_total)
  );

  function automatic void load_window(logic [swer_pkg::CFG_W-1:0] value);
    window_q = value;
    for (int i = 0; i < WINDOW_SLOTS; i++) bucket_q[i] = '0;
    total_q = '0;
    slot_q = 0;
  endfunction

  function automatic logic [swer_pkg::TOTAL_W-1:0] count_events(
      logic [swer_pkg::NOW_W-1:0] now, logic [swer_pkg::ADD_W-1:0] add);
    int unsigned w;
    int unsigned steps;
    logic [swer_pkg::NOW_W-1:0] gap;
    logic [swer_pkg::BUCKET_W-1:0] room_b;
    logic [swer_pkg::TOTAL_W-1:0] room_t;
    logic [swer_pkg::TOTAL_W-1:0] amount;
    w = (window_q == 0) ? 1 : ((window_q > WINDOW_SLOTS) ? WINDOW_SLOTS : window_q);
    if (slot_q >= w) slot_q = 0;
    if (now > last_q) begin
      gap = now - last_q;
      steps = (gap < w) ? gap : w;
      repeat (steps) begin
        slot_q = (slot_q + 1 >= w) ? 0 : slot_q + 1;
        total_q -= swer_pkg::TOTAL_W'(bucket_q[slot_q]);
        bucket_q[slot_q] = '0;
      end
      last_q = now;
    end
    amount = swer_pkg::TOTAL_W'(add);
    room_b = swer_pkg::BUCKET_MAX - bucket_q[slot_q];
    if (amount > swer_pkg::TOTAL_W'(room_b)) amount = swer_pkg::TOTAL_W'(room_b);
    room_t = swer_pkg::TOTAL_MAX - total_q;
    if (amount > room_t) amount = room_t;
    bucket_q[slot_q] += swer_pkg::BUCKET_W'(amount);
    total_q += amount;
    return total_q;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (arrivals.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_item = arrivals.pop_front();
        in_valid <= 1'b1;
        in_now_seconds <= next_item.now;
        in_add_count <= next_item.add;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected window_total %0d", out_window_total);
        end else begin
          want_total = totals_due.pop_front();
          if (out_window_total !== want_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("window_total mismatch: expected %0d, got %0d",
                       want_total, out_window_total);
            end
          end
        end
      end
      if (in_valid && in_ready) totals_due.push_back(count_events(in_now_seconds, in_add_count));
    end
  end

  task automatic queue_item(logic [swer_pkg::NOW_W-1:0] now, logic [swer_pkg::ADD_W-1:0] add);
    stamp_t item;
    item.now = now;
    item.add = add;
    if (now > gen_now) gen_now = now;
    arrivals.push_back(item);
  endtask

  task automatic queue_traffic(int count, bit saturate);
    stamp_t item;
    int unsigned pick;
    logic [swer_pkg::NOW_W-1:0] step;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (saturate || pick < 40) step = '0;
      else if (pick < 65) step = 1;
      else if (pick < 80) step = $urandom_range(70, 2);
      else if (pick < 88) step = $urandom_range(5000, 65);
      else if (pick < 92) step = $urandom_range(32'h10_0000, 1);
      else step = '0;
      if (gen_now < 32'hF000_0000) gen_now += step;
      item.now = (!saturate && pick >= 92) ? $urandom_range(gen_now) : gen_now;
      pick = $urandom_range(99);
      if (saturate) item.add = (pick < 90) ? 16'hFFFF : 16'($urandom_range(3));
      else if (pick < 25) item.add = '0;
      else if (pick < 60) item.add = 16'($urandom_range(20, 1));
      else if (pick < 85) item.add = 16'($urandom());
      else item.add = 16'hFFFF;
      arrivals.push_back(item);
    end
  endtask

  task automatic wait_idle();
    while (arrivals.size() != 0 || in_valid || totals_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(logic [swer_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_window_seconds <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_window(value);
    @(negedge clk);
  endtask

  task automatic run_phase(bit rewrite, logic [swer_pkg::CFG_W-1:0] window, int idle,
                           int stall, int count, bit saturate);
    if (rewrite) write_window(window);
    idle_pct = idle;
    stall_pct = stall;
    queue_traffic(count, saturate);
    wait_idle();
  endtask

  initial begin
    load_window(swer_pkg::CFG_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_item(0, 0);
    queue_item(0, 5);
    queue_item(0, 16'hFFFF);
    queue_item(1, 1);
    queue_item(1, 0);
    queue_item(3, 7);
    queue_item(2, 9);
    queue_item(0, 4);
    queue_item(62, 3);
    queue_item(63, 0);
    queue_item(64, 1);
    queue_item(200, 2);
    queue_item(200, 16'hFFFF);
    queue_item(32'h8000_0000, 11);
    queue_item(32'h8000_003B, 1);
    queue_item(32'h8000_003C, 0);
    queue_item(32'h1234_5678, 6);
    wait_idle();

    run_phase(1'b1, 7'd1, 77, 0, 200, 1'b0);
    run_phase(1'b1, 7'd64, 0, 77, 250, 1'b0);
    run_phase(1'b1, 7'd0, 20, 20, 150, 1'b0);
    run_phase(1'b1, 7'd127, 0, 0, 200, 1'b0);
    run_phase(1'b0, 7'd0, 20, 20, 300, 1'b1);
    run_phase(1'b1, 7'd2, 77, 0, 150, 1'b0);
    run_phase(1'b1, 7'($urandom_range(63, 3)), 0, 77, 250, 1'b0);
    run_phase(1'b1, 7'd65, 20, 20, 100, 1'b0);

    // the last second seen by the counter never moves backwards, so the top of the time range comes last
    write_window(7'd1);
    idle_pct = 0;
    stall_pct = 0;
    queue_item(32'hFFFF_FFFE, 1);
    queue_item(32'hFFFF_FFFF, 16'hFFFF);
    queue_item(32'hFFFF_FFFF, 0);
    queue_item(0, 2);
    queue_item(32'h7FFF_FFFF, 5);
    wait_idle();

    repeat (80) @(posedge clk);
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
